// File: hdl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants of the cosine top-k search block.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int SLOT_IN_W  = 6;
    localparam int IDX_W      = 4;
    localparam int VAL_IN_W   = 16;
    localparam int LIMIT_W    = 7;
    localparam int LEN_W      = 5;
    localparam int SCORE_W    = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_QUERY  = 2'd1,
        OP_REMOVE = 2'd2
    } op_kind_t;

    // one decoded item handed from the front to the back
    typedef struct packed {
        op_kind_t              kind;
        logic [SLOT_IN_W-1:0]  slot;
        logic [IDX_W-1:0]      elem;
        logic [VAL_IN_W-1:0]   value;
        logic                  last;
        logic [LIMIT_W-1:0]    limit;
    } op_t;

endpackage

// File: hdl/cts_ram.sv
// ----------------------------------------------------------------------------
// cts_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/cts_score.sv
// ----------------------------------------------------------------------------
// cts_score
// Serial cosine score: shift-add products, restoring division, bitwise root.
// score = round(32768*|dot|/sqrt(n1*n2)), negated for negative dot.
// ----------------------------------------------------------------------------
module cts_score
    import cts_pkg::*;
#(
    parameter int EW = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [2*EW+3:0]           n1,
    input  logic [2*EW+3:0]           n2,
    input  logic signed [2*EW+4:0]    dot,
    output logic                      done,
    output logic signed [SCORE_W-1:0] score
);

    localparam int MW    = 2*EW + 4;
    localparam int PW    = 2*MW;
    localparam int DW    = PW + 32;
    localparam int CNT_W = $clog2(DW + 1);
    localparam int SQ_STEPS = 17;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_SQRT = 5'b01000,
        S_DONE = 5'b10000
    } sstate_t;

    sstate_t            state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PW-1:0]      ma_reg, ma_next, sa_reg, sa_next;
    logic [MW-1:0]      mb_reg, mb_next, sb_reg, sb_next;
    logic [PW-1:0]      p_reg, p_next, r_reg, r_next;
    logic [DW-1:0]      div_reg, div_next;
    logic [PW-1:0]      rem_reg, rem_next;
    logic [32:0]        quo_reg, quo_next;
    logic [33:0]        sq_reg, sq_next;
    logic [19:0]        srem_reg, srem_next;
    logic [17:0]        root_reg, root_next;
    logic               neg_reg, neg_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;

    logic [MW-1:0]      mag;
    logic [PW:0]        rem_sh;
    logic [21:0]        srem_sh;
    logic [21:0]        trial;
    logic [17:0]        qv;

    assign mag = dot[MW] ? MW'(-dot) : MW'(dot);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        p_next     = p_reg;
        r_next     = r_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        sq_next    = sq_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        neg_next   = neg_reg;
        score_next = score_reg;
        rem_sh     = {rem_reg, div_reg[DW-1]};
        srem_sh    = {srem_reg, sq_reg[33:32]};
        trial      = {2'b00, root_reg, 2'b01};
        qv         = (root_reg + 18'd1) >> 1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (n1 == '0 || n2 == '0)
                    begin
                        score_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ma_next    = PW'(n1);
                        mb_next    = n2;
                        sa_next    = PW'(mag);
                        sb_next    = mag;
                        p_next     = '0;
                        r_next     = '0;
                        neg_next   = dot[MW];
                        cnt_next   = '0;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                if (cnt_reg == CNT_W'(MW))
                begin
                    div_next   = {r_reg, 32'd0};
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    if (mb_reg[0])
                    begin
                        p_next = p_reg + ma_reg;
                    end
                    if (sb_reg[0])
                    begin
                        r_next = r_reg + sa_reg;
                    end
                    ma_next  = ma_reg << 1;
                    mb_next  = mb_reg >> 1;
                    sa_next  = sa_reg << 1;
                    sb_next  = sb_reg >> 1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(DW))
                begin
                    sq_next    = {1'b0, quo_reg};
                    srem_next  = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    div_next = div_reg << 1;
                    if (rem_sh >= {1'b0, p_reg})
                    begin
                        rem_next = PW'(rem_sh - {1'b0, p_reg});
                        quo_next = {quo_reg[31:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = PW'(rem_sh);
                        quo_next = {quo_reg[31:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SQRT:
            begin
                if (cnt_reg == CNT_W'(SQ_STEPS))
                begin
                    // round half up in magnitude, cap positive side
                    if (neg_reg)
                    begin
                        score_next = SCORE_W'(18'd0 - qv);
                    end
                    else if (qv > 18'd32767)
                    begin
                        score_next = 16'sd32767;
                    end
                    else
                    begin
                        score_next = SCORE_W'(qv);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    sq_next = sq_reg << 2;
                    if (srem_sh >= trial)
                    begin
                        srem_next = 20'(srem_sh - trial);
                        root_next = {root_reg[16:0], 1'b1};
                    end
                    else
                    begin
                        srem_next = 20'(srem_sh);
                        root_next = {root_reg[16:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        sa_reg    <= sa_next;
        sb_reg    <= sb_next;
        p_reg     <= p_next;
        r_reg     <= r_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        sq_reg    <= sq_next;
        srem_reg  <= srem_next;
        root_reg  <= root_next;
        neg_reg   <= neg_next;
        score_reg <= score_next;
    end

    assign done  = (state_reg == S_DONE);
    assign score = score_reg;

endmodule

// File: hdl/cts_front.sv
// ----------------------------------------------------------------------------
// cts_front
// Accepts input items, drops the ones with no effect, queues the rest.
// ----------------------------------------------------------------------------
module cts_front
    import cts_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int DIMENSIONS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 s_tlast,
    output logic                 op_valid,
    input  logic                 op_ready,
    output op_t                  op
);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    op_t              q_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     cnt_reg;

    logic [SLOT_IN_W-1:0] slot;
    logic [IDX_W-1:0]     elem;
    logic                 slot_ok, elem_ok, keep;
    logic                 push, pop;
    op_t                  item;

    assign slot = s_tdata[5:0];
    assign elem = s_tdata[9:6];
    assign slot_ok = int'(slot) < ENTRIES;
    assign elem_ok = int'(elem) < DIMENSIONS;

    always_comb
    begin
        item.slot  = slot;
        item.elem  = elem;
        item.value = s_tdata[25:10];
        item.last  = s_tlast;
        item.limit = s_tdata[32:26];
        item.kind  = OP_LOAD;
        keep       = 1'b0;
        unique case (s_tuser)
            CMD_LOAD:
            begin
                item.kind = OP_LOAD;
                keep      = slot_ok && elem_ok;
            end
            CMD_QUERY:
            begin
                item.kind = OP_QUERY;
                keep      = elem_ok;
            end
            CMD_REMOVE:
            begin
                item.kind = OP_REMOVE;
                keep      = slot_ok;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = (cnt_reg != (QAW+1)'(QDEPTH));
    assign push     = s_tvalid && s_tready && keep;
    assign op_valid = (cnt_reg != '0);
    assign pop      = op_valid && op_ready;
    assign op       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// File: hdl/cts_back.sv
// ----------------------------------------------------------------------------
// cts_back
// Executes queued items: stores or removes vectors, scores all valid slots on the last
// query element, then ranks by repeated scans of the score buffer.
// ----------------------------------------------------------------------------
module cts_back
    import cts_pkg::*;
#(
    parameter int ENTRIES      = 64,
    parameter int DIMENSIONS   = 16,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    output logic                  op_ready,
    input  op_t                   op,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    localparam int EW  = (ELEMENT_BITS < 16) ? ELEMENT_BITS : 16;
    localparam int SW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DAW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int MW  = 2*EW + 4;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_SLOT  = 8'b00000010,
        ST_LEN   = 8'b00000100,
        ST_ACC   = 8'b00001000,
        ST_SCORE = 8'b00010000,
        ST_RANK  = 8'b00100000,
        ST_SCAN  = 8'b01000000,
        ST_EMIT  = 8'b10000000
    } bstate_t;

    bstate_t             state_reg, state_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [ENTRIES-1:0]  taken_reg, taken_next;
    logic [LEN_W-1:0]    qlen_reg, qlen_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [LIMIT_W-1:0]  rank_limit_reg, rank_limit_next;
    logic [LIMIT_W-1:0]  round_reg, round_next;
    logic [CW-1:0]       slot_reg, slot_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic                scan_vld_reg, scan_vld_next;
    logic [SW-1:0]       scan_slot_reg, scan_slot_next;
    logic                have_best_reg, have_best_next;
    logic [SW-1:0]       best_reg, best_next;
    logic signed [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [LEN_W-1:0]    n_reg, n_next;
    logic [LEN_W-1:0]    elem_reg, elem_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                prod_vld_reg, prod_vld_next;
    logic signed [2*EW-1:0] pdot_reg, pdot_next;
    logic [2*EW-1:0]     pq_reg, pq_next, pe_reg, pe_next;
    logic signed [MW:0]  dot_reg, dot_next;
    logic [MW-1:0]       n1_reg, n1_next, n2_reg, n2_next;
    logic                out_valid_reg, out_valid_next;
    logic [SLOT_IN_W-1:0] out_entry_reg, out_entry_next;
    logic [SCORE_W-1:0]  out_score_reg, out_score_next;
    logic                out_last_reg, out_last_next;

    // memory ports
    logic                 ent_we, qry_we, len_we, scr_we;
    logic [SW+DAW-1:0]    ent_waddr, ent_raddr;
    logic [DAW-1:0]       qry_waddr, qry_raddr;
    logic [SW-1:0]        op_slot;
    logic [EW-1:0]        ent_rdata, qry_rdata, elem_val;
    logic [LEN_W-1:0]     len_wdata, len_rdata;
    logic [SCORE_W-1:0]   scr_rdata;

    logic                 score_start, score_done;
    logic signed [SCORE_W-1:0] score_val;
    logic                 emit_fire;
    logic signed [EW-1:0] qs, es;

    assign op_slot   = SW'(op.slot);
    assign elem_val  = op.value[EW-1:0];
    assign ent_waddr = {op_slot, DAW'(op.elem)};
    assign qry_waddr = DAW'(op.elem);
    assign len_wdata = {1'b0, op.elem} + 5'd1;
    assign ent_raddr = {slot_reg[SW-1:0], DAW'(elem_reg)};
    assign qry_raddr = DAW'(elem_reg);
    assign qs        = $signed(qry_rdata);
    assign es        = $signed(ent_rdata);

    assign op_ready  = (state_reg == ST_IDLE);
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        taken_next      = taken_reg;
        qlen_next       = qlen_reg;
        limit_next      = limit_reg;
        rank_limit_next = rank_limit_reg;
        round_next      = round_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        scan_vld_next   = 1'b0;
        scan_slot_next  = scan_slot_reg;
        have_best_next  = have_best_reg;
        best_next       = best_reg;
        best_score_next = best_score_reg;
        n_next          = n_reg;
        elem_next       = elem_reg;
        rd_vld_next     = 1'b0;
        prod_vld_next   = 1'b0;
        pdot_next       = pdot_reg;
        pq_next         = pq_reg;
        pe_next         = pe_reg;
        dot_next        = dot_reg;
        n1_next         = n1_reg;
        n2_next         = n2_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_entry_next  = out_entry_reg;
        out_score_next  = out_score_reg;
        out_last_next   = out_last_reg;
        ent_we          = 1'b0;
        qry_we          = 1'b0;
        len_we          = 1'b0;
        scr_we          = 1'b0;
        score_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    unique case (op.kind)
                        OP_LOAD:
                        begin
                            ent_we = 1'b1;
                            if (op.last)
                            begin
                                len_we = 1'b1;
                                valid_next[op_slot] = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            valid_next[op_slot] = 1'b0;
                        end
                        OP_QUERY:
                        begin
                            qry_we = 1'b1;
                            if (op.last)
                            begin
                                qlen_next  = len_wdata;
                                limit_next = op.limit;
                                slot_next  = '0;
                                count_next = '0;
                                state_next = ST_SLOT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SLOT:
            begin
                priority if (slot_reg == CW'(ENTRIES))
                begin
                    rank_limit_next = (limit_reg > LIMIT_W'(count_reg)) ?
                                      LIMIT_W'(count_reg) : limit_reg;
                    round_next = '0;
                    taken_next = '0;
                    state_next = ST_RANK;
                end
                else if (!valid_reg[slot_reg[SW-1:0]])
                begin
                    slot_next = slot_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                n_next     = (qlen_reg < len_rdata) ? qlen_reg : len_rdata;
                elem_next  = '0;
                dot_next   = '0;
                n1_next    = '0;
                n2_next    = '0;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (elem_reg < n_reg)
                begin
                    elem_next   = elem_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    pdot_next     = qs * es;
                    pq_next       = (2*EW)'(qs * qs);
                    pe_next       = (2*EW)'(es * es);
                    prod_vld_next = 1'b1;
                end
                if (prod_vld_reg)
                begin
                    dot_next = dot_reg + (MW+1)'(pdot_reg);
                    n1_next  = n1_reg + MW'(pq_reg);
                    n2_next  = n2_reg + MW'(pe_reg);
                end
                if (elem_reg == n_reg && !rd_vld_reg && !prod_vld_reg)
                begin
                    score_start = 1'b1;
                    state_next  = ST_SCORE;
                end
            end
            ST_SCORE:
            begin
                if (score_done)
                begin
                    scr_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_SLOT;
                end
            end
            ST_RANK:
            begin
                if (round_reg == rank_limit_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next      = '0;
                    have_best_next = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg != CW'(ENTRIES))
                begin
                    scan_next      = scan_reg + 1'b1;
                    scan_vld_next  = 1'b1;
                    scan_slot_next = scan_reg[SW-1:0];
                end
                if (scan_vld_reg && valid_reg[scan_slot_reg] && !taken_reg[scan_slot_reg])
                begin
                    // strict compare keeps the lower slot on ties
                    if (!have_best_reg || $signed(scr_rdata) > best_score_reg)
                    begin
                        have_best_next  = 1'b1;
                        best_next       = scan_slot_reg;
                        best_score_next = $signed(scr_rdata);
                    end
                end
                if (scan_reg == CW'(ENTRIES) && !scan_vld_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next        = 1'b1;
                    out_entry_next        = SLOT_IN_W'(best_reg);
                    out_score_next        = best_score_reg;
                    out_last_next         = (round_reg + 1'b1 == rank_limit_reg);
                    taken_next[best_reg]  = 1'b1;
                    round_next            = round_reg + 1'b1;
                    state_next            = ST_RANK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            taken_reg     <= '0;
            qlen_reg      <= '0;
            round_reg     <= '0;
            rank_limit_reg <= '0;
            slot_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            scan_vld_reg  <= 1'b0;
            have_best_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            taken_reg     <= taken_next;
            qlen_reg      <= qlen_next;
            round_reg     <= round_next;
            rank_limit_reg <= rank_limit_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            scan_vld_reg  <= scan_vld_next;
            have_best_reg <= have_best_next;
            rd_vld_reg    <= rd_vld_next;
            prod_vld_reg  <= prod_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg      <= limit_next;
        scan_slot_reg  <= scan_slot_next;
        best_reg       <= best_next;
        best_score_reg <= best_score_next;
        n_reg          <= n_next;
        elem_reg       <= elem_next;
        pdot_reg       <= pdot_next;
        pq_reg         <= pq_next;
        pe_reg         <= pe_next;
        dot_reg        <= dot_next;
        n1_reg         <= n1_next;
        n2_reg         <= n2_next;
        out_entry_reg  <= out_entry_next;
        out_score_reg  <= out_score_next;
        out_last_reg   <= out_last_next;
    end

    cts_ram #(.WIDTH(EW), .DEPTH((2**SW) * (2**DAW))) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (elem_val),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    cts_ram #(.WIDTH(EW), .DEPTH(2**DAW)) u_query_ram (
        .clk   (clk),
        .we    (qry_we),
        .waddr (qry_waddr),
        .wdata (elem_val),
        .raddr (qry_raddr),
        .rdata (qry_rdata)
    );

    cts_ram #(.WIDTH(LEN_W), .DEPTH(2**SW)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (op_slot),
        .wdata (len_wdata),
        .raddr (slot_reg[SW-1:0]),
        .rdata (len_rdata)
    );

    cts_ram #(.WIDTH(SCORE_W), .DEPTH(2**SW)) u_score_ram (
        .clk   (clk),
        .we    (scr_we),
        .waddr (slot_reg[SW-1:0]),
        .wdata (score_val),
        .raddr (scan_reg[SW-1:0]),
        .rdata (scr_rdata)
    );

    cts_score #(.EW(EW)) u_score (
        .clk   (clk),
        .rst_n (rst_n),
        .start (score_start),
        .n1    (n1_reg),
        .n2    (n2_reg),
        .dot   (dot_reg),
        .done  (score_done),
        .score (score_val)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_score_reg, out_entry_reg};
    assign m_tlast  = out_last_reg;

    a_emit_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> have_best_reg)
        else $error("result emitted without a selected slot");

    a_emit_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> !taken_reg[best_reg] && valid_reg[best_reg])
        else $error("slot reported twice or not valid");

    a_score_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCORE && score_done) |-> valid_reg[slot_reg[SW-1:0]])
        else $error("score written for an invalid slot");

    a_rank_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (round_reg < rank_limit_reg))
        else $error("more results than the limit");

endmodule

// File: hdl/cosine_top_k_search.sv
// ----------------------------------------------------------------------------
// cosine_top_k_search
// Cosine-similarity top-k search over stored vectors.
// ----------------------------------------------------------------------------
// Input stream (s_*): load, remove and query items; command in s_tuser,
// vector end mark in s_tlast. Output stream (m_*): one item per reported
// slot, best first, m_tlast on the final one of a query.
// Load, remove and non-last query items are taken one per cycle through a
// four-deep queue while no search is running. The last query element scores
// every valid slot in turn: length and element reads, then the serial score
// unit (products, division, root and hand-off) on EW = min(ELEMENT_BITS,16)
// bit elements; an invalid slot is skipped. Ranking then scans the score
// buffer once per result. First result appears after the scoring plus one
// scan. During a search the queue fills and s_tready drops.
// A stalled receiver holds the output register; the ranking waits on it.
// Reset clears all valid marks and the query length; vector storage holds
// no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module cosine_top_k_search
    import cts_pkg::*;
#(
    parameter int ENTRIES      = 64,
    parameter int DIMENSIONS   = 16,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // entry_index, element_index, element_value, result_limit, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command
    input  logic [1:0]            s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_entry, result_similarity, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    op_t  op;
    logic op_valid, op_ready;

    cts_front #(.ENTRIES(ENTRIES), .DIMENSIONS(DIMENSIONS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    cts_back #(
        .ENTRIES      (ENTRIES),
        .DIMENSIONS   (DIMENSIONS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
